/* design/pph_pkg.sv */
// Package for the per-position score histogram.
// Holds default sizes, port widths, action codes, controller states and the
// command/status structs shared by the controller, datapath and top level.
package pph_pkg;

    localparam int MAX_LEN_DEF    = 256;
    localparam int SCORE_BINS_DEF = 256;
    localparam int COUNT_BITS_DEF = 32;

    localparam int BYTE_W    = 8;
    localparam int BIN_OUT_W = 32;
    localparam int LONGEST_W = 9;

    localparam logic ACT_TALLY = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic mem_read;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
    } status_t;

endpackage

/* design/per_position_score_histogram.sv */
// Top level of the per-position score histogram.
// Instantiates pph_ctrl and pph_datapath; uses pph_pkg.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. action
//   selects a tally of score_byte at the current read position (read_ends
//   marks the last byte of a read) or a lookup of the count at
//   query_position / query_score.
//   Every item gives one result: done is high for one cycle with bin_count,
//   longest_read and position_overflow valid in that cycle.
//   After the accepting edge the controller steps through READ and UPDATE,
//   and done is registered from UPDATE. No new item is taken before the read,
//   increment and write-back of the single-port count memory (registered read
//   data) are through. busy drops in the cycle that done is high, so the next
//   item may be started then.
//   Reset: the count memory is cleared by a sweep of one entry per cycle over
//   all MAX_LEN * SCORE_BINS entries (65536 by default), with busy high.
//   The receiver cannot stall; results are not held.
module per_position_score_histogram
#(
    parameter int MAX_LEN    = pph_pkg::MAX_LEN_DEF,
    parameter int SCORE_BINS = pph_pkg::SCORE_BINS_DEF,
    parameter int COUNT_BITS = pph_pkg::COUNT_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           action,
    input  logic [pph_pkg::BYTE_W-1:0]     score_byte,
    input  logic                           read_ends,
    input  logic [pph_pkg::BYTE_W-1:0]     query_position,
    input  logic [pph_pkg::BYTE_W-1:0]     query_score,
    output logic                           done,
    output logic [pph_pkg::BIN_OUT_W-1:0]  bin_count,
    output logic [pph_pkg::LONGEST_W-1:0]  longest_read,
    output logic                           position_overflow
);
    import pph_pkg::*;

    cmd_t    cmd;
    status_t status;

    pph_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    pph_datapath
    #(
        .MAX_LEN    (MAX_LEN),
        .SCORE_BINS (SCORE_BINS),
        .COUNT_BITS (COUNT_BITS)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .action            (action),
        .score_byte        (score_byte),
        .read_ends         (read_ends),
        .query_position    (query_position),
        .query_score       (query_score),
        .done              (done),
        .bin_count         (bin_count),
        .longest_read      (longest_read),
        .position_overflow (position_overflow)
    );

endmodule

/* design/pph_ctrl.sv */
// Controller state machine for the per-position score histogram.
// Depends on pph_pkg; drives datapath commands and the busy handshake.
module pph_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pph_pkg::status_t status,
    output pph_pkg::cmd_t   cmd,
    output logic            busy
);
    import pph_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* design/pph_datapath.sv */
// Datapath for the per-position score histogram: count memory, clear sweep,
// read position tracking, saturating increment and result registers. Uses pph_pkg.
module pph_datapath
#(
    parameter int MAX_LEN    = pph_pkg::MAX_LEN_DEF,
    parameter int SCORE_BINS = pph_pkg::SCORE_BINS_DEF,
    parameter int COUNT_BITS = pph_pkg::COUNT_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pph_pkg::cmd_t                  cmd,
    output pph_pkg::status_t               status,
    input  logic                           action,
    input  logic [pph_pkg::BYTE_W-1:0]     score_byte,
    input  logic                           read_ends,
    input  logic [pph_pkg::BYTE_W-1:0]     query_position,
    input  logic [pph_pkg::BYTE_W-1:0]     query_score,
    output logic                           done,
    output logic [pph_pkg::BIN_OUT_W-1:0]  bin_count,
    output logic [pph_pkg::LONGEST_W-1:0]  longest_read,
    output logic                           position_overflow
);
    import pph_pkg::*;

    localparam int DEPTH  = MAX_LEN * SCORE_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);

    logic [COUNT_BITS-1:0] mem [DEPTH];

    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [ADDR_W-1:0]     addr_next;
    logic                  action_reg;
    logic                  skip_reg;
    logic                  skip_next;
    logic                  overflow_reg;
    logic [LEN_W-1:0]      pos_reg;
    logic [LEN_W-1:0]      pos_next;
    logic [LEN_W-1:0]      longest_reg;
    logic [LEN_W-1:0]      longest_next;
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [COUNT_BITS-1:0] count_inc;
    logic [ADDR_W-1:0]     score_idx;
    logic [LEN_W-1:0]      len;
    logic                  at_end;
    logic                  write_en;
    logic                  done_reg;
    logic [BIN_OUT_W-1:0]  bin_count_reg;
    logic [BIN_OUT_W-1:0]  bin_count_next;
    logic                  overflow_out_reg;

    assign status.clear_done = (clr_addr_reg == ADDR_W'(DEPTH - 1));

    always_comb
    begin
        at_end = (pos_reg == LEN_W'(MAX_LEN));
        len    = at_end ? LEN_W'(MAX_LEN) : pos_reg + 1'b1;
        if (32'(score_byte) >= SCORE_BINS)
        begin
            score_idx = ADDR_W'(SCORE_BINS - 1);
        end
        else
        begin
            score_idx = ADDR_W'(score_byte);
        end
        pos_next     = pos_reg;
        longest_next = longest_reg;
        if (action == ACT_TALLY)
        begin
            addr_next = ADDR_W'(pos_reg) * ADDR_W'(SCORE_BINS) + score_idx;
            skip_next = at_end;
            if (len > longest_reg)
            begin
                longest_next = len;
            end
            pos_next = read_ends ? '0 : len;
        end
        else
        begin
            addr_next = ADDR_W'(query_position) * ADDR_W'(SCORE_BINS)
                        + ADDR_W'(query_score);
            skip_next = (32'(query_position) >= MAX_LEN)
                        || (32'(query_score) >= SCORE_BINS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            pos_reg      <= '0;
            longest_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.capture)
            begin
                pos_reg     <= pos_next;
                longest_reg <= longest_next;
            end
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg     <= addr_next;
            action_reg   <= action;
            skip_reg     <= skip_next;
            overflow_reg <= (action == ACT_TALLY) && at_end;
        end
        if (cmd.update)
        begin
            bin_count_reg    <= bin_count_next;
            overflow_out_reg <= overflow_reg;
        end
    end

    // saturating increment
    assign count_inc = (rdata_reg == '1) ? rdata_reg : rdata_reg + 1'b1;
    assign write_en  = cmd.update && (action_reg == ACT_TALLY) && !skip_reg;

    always_comb
    begin
        if (skip_reg)
        begin
            bin_count_next = '0;
        end
        else if (action_reg == ACT_TALLY)
        begin
            bin_count_next = BIN_OUT_W'(count_inc);
        end
        else
        begin
            bin_count_next = BIN_OUT_W'(rdata_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (write_en)
        begin
            mem[addr_reg] <= count_inc;
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign done              = done_reg;
    assign bin_count         = bin_count_reg;
    assign longest_read      = LONGEST_W'(longest_reg);
    assign position_overflow = overflow_out_reg;

endmodule

/* design/pph_checker.sv */
// Port-level checker for the per-position score histogram, bound to the top.
// Uses pph_pkg for port widths.
module pph_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [pph_pkg::BIN_OUT_W-1:0] bin_count,
    input logic                          position_overflow
);
    import pph_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after item accepted");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("result strobe missing three cycles after accept");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && position_overflow |-> bin_count == '0)
        else $error("dropped byte reported a nonzero count");

endmodule

bind per_position_score_histogram pph_checker u_pph_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .bin_count         (bin_count),
    .position_overflow (position_overflow)
);

/* tb/per_position_score_histogram_tb.sv */
// Testbench for per_position_score_histogram: directed and random tally/lookup items,
// each result checked against an in-bench histogram predictor.
// Depends on pph_pkg and the per_position_score_histogram top level.
module per_position_score_histogram_tb;

    import pph_pkg::*;

    localparam int MAX_LEN        = MAX_LEN_DEF;
    localparam int SCORE_BINS     = SCORE_BINS_DEF;
    localparam int COUNT_BITS     = COUNT_BITS_DEF;
    localparam int TOTAL_ITEMS    = 1300;
    localparam int STREAM_ITEMS   = 150;
    localparam int WATCHDOG_LIMIT = 262144;
    localparam longint unsigned COUNT_MAX = (COUNT_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                               : (64'd1 << COUNT_BITS) - 64'd1;

    typedef struct {
        bit                action;
        bit [BYTE_W-1:0]   score_byte;
        bit                read_ends;
        bit [BYTE_W-1:0]   query_position;
        bit [BYTE_W-1:0]   query_score;
    } hist_item_t;

    typedef struct {
        bit [BIN_OUT_W-1:0] bin_count;
        bit [LONGEST_W-1:0] longest_read;
        bit                 position_overflow;
    } hist_result_t;

    typedef struct {
        bit [BYTE_W-1:0] pos;
        bit [BYTE_W-1:0] score;
    } bin_ref_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 action;
    logic [BYTE_W-1:0]    score_byte;
    logic                 read_ends;
    logic [BYTE_W-1:0]    query_position;
    logic [BYTE_W-1:0]    query_score;
    logic                 done;
    logic [BIN_OUT_W-1:0] bin_count;
    logic [LONGEST_W-1:0] longest_read;
    logic                 position_overflow;

    // predictor state
    longint unsigned bin_table [MAX_LEN*SCORE_BINS];
    int unsigned     read_pos;
    int unsigned     longest_len;

    hist_result_t    expected_counts[$];
    bin_ref_t        recent_bins[$];

    int unsigned     items_sent;
    int unsigned     tallies_sent;
    int unsigned     lookups_sent;
    int unsigned     dropped_bytes;
    int unsigned     reads_ended;
    int unsigned     results_checked = 0;
    int unsigned     error_count = 0;
    int unsigned     idle_pct;
    int unsigned     stall_cycles = 0;

    per_position_score_histogram dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .action            (action),
        .score_byte        (score_byte),
        .read_ends         (read_ends),
        .query_position    (query_position),
        .query_score       (query_score),
        .done              (done),
        .bin_count         (bin_count),
        .longest_read      (longest_read),
        .position_overflow (position_overflow)
    );

    always #6 clk = ~clk;

    function automatic hist_result_t histogram_step(input hist_item_t item);
        hist_result_t r;
        int unsigned  pos;
        int unsigned  len;
        int unsigned  bin;
        int unsigned  idx;
        r = '{default: '0};
        if (item.action == ACT_TALLY)
        begin
            pos = read_pos;
            bin = (item.score_byte >= SCORE_BINS) ? SCORE_BINS - 1 : item.score_byte;
            if (pos < MAX_LEN)
            begin
                idx = pos * SCORE_BINS + bin;
                if (bin_table[idx] < COUNT_MAX)
                    bin_table[idx]++;
                r.bin_count = 32'(bin_table[idx]);
                len = pos + 1;
            end
            else
            begin
                r.position_overflow = 1'b1;
                len = MAX_LEN;
            end
            if (len > longest_len)
                longest_len = len;
            read_pos = item.read_ends ? 0 : len;
        end
        else if (item.query_position < MAX_LEN && item.query_score < SCORE_BINS)
        begin
            r.bin_count = 32'(bin_table[item.query_position * SCORE_BINS + item.query_score]);
        end
        r.longest_read = LONGEST_W'(longest_len);
        return r;
    endfunction

    function automatic hist_item_t tally_item(input bit [BYTE_W-1:0] score, input bit ends);
        hist_item_t item;
        item.action         = ACT_TALLY;
        item.score_byte     = score;
        item.read_ends      = ends;
        item.query_position = BYTE_W'($urandom);
        item.query_score    = BYTE_W'($urandom);
        return item;
    endfunction

    function automatic hist_item_t lookup_item(input bit [BYTE_W-1:0] pos,
                                               input bit [BYTE_W-1:0] score);
        hist_item_t item;
        item.action         = ACT_QUERY;
        item.score_byte     = BYTE_W'($urandom);
        item.read_ends      = 1'($urandom);
        item.query_position = pos;
        item.query_score    = score;
        return item;
    endfunction

    // mostly typical phred+33 range so bins collide and counts climb
    function automatic bit [BYTE_W-1:0] pick_score();
        if ($urandom_range(0, 99) < 85)
            return BYTE_W'($urandom_range(33, 73));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic hist_item_t random_lookup();
        bin_ref_t ref_bin;
        if (recent_bins.size() != 0 && $urandom_range(0, 99) < 70)
        begin
            ref_bin = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
            return lookup_item(ref_bin.pos, ref_bin.score);
        end
        return lookup_item(BYTE_W'($urandom), BYTE_W'($urandom));
    endfunction

    task automatic issue_item(input hist_item_t item);
        hist_result_t want;
        bin_ref_t     ref_bin;
        int unsigned  pre_pos;
        action         <= item.action;
        score_byte     <= item.score_byte;
        read_ends      <= item.read_ends;
        query_position <= item.query_position;
        query_score    <= item.query_score;
        start          <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pre_pos = read_pos;
        want = histogram_step(item);
        expected_counts.push_back(want);
        items_sent++;
        if (item.action == ACT_TALLY)
        begin
            tallies_sent++;
            if (want.position_overflow)
                dropped_bytes++;
            else
            begin
                ref_bin.pos   = BYTE_W'(pre_pos);
                ref_bin.score = item.score_byte;
                recent_bins.push_back(ref_bin);
                if (recent_bins.size() > 64)
                    void'(recent_bins.pop_front());
            end
            if (item.read_ends)
                reads_ended++;
        end
        else
            lookups_sent++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send_read(input int unsigned len, input int unsigned lookup_pct);
        int unsigned i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < lookup_pct)
                issue_item(random_lookup());
            issue_item(tally_item(pick_score(), i == len - 1));
        end
        repeat ($urandom_range(0, 2))
            issue_item(random_lookup());
    endtask

    task automatic test_after_reset();
        issue_item(lookup_item(8'd0, 8'd0));
        issue_item(lookup_item(8'd255, 8'd255));
        issue_item(lookup_item(8'd0, 8'd255));
        issue_item(lookup_item(8'd255, 8'd0));
        issue_item(lookup_item(8'hAA, 8'h55));
    endtask

    task automatic test_tally_extremes();
        issue_item(tally_item(8'd0, 1'b1));
        issue_item(tally_item(8'd255, 1'b0));
        issue_item(tally_item(8'd0, 1'b0));
        issue_item(lookup_item(8'd0, 8'd255));    // mid-read lookup
        issue_item(tally_item(8'hAA, 1'b0));
        issue_item(tally_item(8'h55, 1'b1));
        issue_item(tally_item(8'd255, 1'b1));
        issue_item(lookup_item(8'd0, 8'd0));
        issue_item(lookup_item(8'd1, 8'd0));
        issue_item(lookup_item(8'd2, 8'hAA));
        issue_item(lookup_item(8'd3, 8'h55));
        issue_item(lookup_item(8'd0, 8'd255));
        issue_item(tally_item(8'd0, 1'b1));
    endtask

    // full-length read, then one that runs past the end of the table
    task automatic test_long_reads();
        int unsigned i;
        idle_pct = 20;
        for (i = 0; i < MAX_LEN; i++)
            issue_item(tally_item(pick_score(), i == MAX_LEN - 1));
        issue_item(lookup_item(BYTE_W'(MAX_LEN - 1), 8'd40));
        for (i = 0; i < MAX_LEN + 6; i++)
        begin
            if (i == MAX_LEN + 2)
                issue_item(random_lookup());
            issue_item(tally_item(BYTE_W'($urandom), i == MAX_LEN + 5));
        end
        issue_item(tally_item(8'd40, 1'b1));
        issue_item(lookup_item(8'd0, 8'd40));
    endtask

    task automatic test_random_reads(input int unsigned stop_at);
        int unsigned len;
        while (items_sent < stop_at)
        begin
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
            if ($urandom_range(0, 29) == 0)
                len = $urandom_range(100, 200);
            else
                len = $urandom_range(1, 40);
            send_read(len, 15);
        end
    endtask

    task automatic test_streaming(input int unsigned stop_at);
        idle_pct = 0;
        while (items_sent < stop_at)
            send_read($urandom_range(1, 30), 20);
    endtask

    always @(posedge clk)
    begin : check_results
        hist_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_counts.size() == 0)
            begin
                $error("result with no item pending");
                error_count++;
            end
            else
            begin
                want = expected_counts.pop_front();
                results_checked++;
                if (bin_count !== want.bin_count)
                begin
                    $error("bin_count: expected %0d, got %0d", want.bin_count, bin_count);
                    error_count++;
                end
                if (longest_read !== want.longest_read)
                begin
                    $error("longest_read: expected %0d, got %0d",
                           want.longest_read, longest_read);
                    error_count++;
                end
                if (position_overflow !== want.position_overflow)
                begin
                    $error("position_overflow: expected %0d, got %0d",
                           want.position_overflow, position_overflow);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", stall_cycles);
            $display("per_position_score_histogram_tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        items_sent      = 0;
        tallies_sent    = 0;
        lookups_sent    = 0;
        dropped_bytes   = 0;
        reads_ended     = 0;
        read_pos        = 0;
        longest_len     = 0;
        idle_pct        = 25;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        action         <= ACT_TALLY;
        score_byte     <= '0;
        read_ends      <= 1'b0;
        query_position <= '0;
        query_score    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_tally_extremes();
        test_long_reads();
        test_random_reads(TOTAL_ITEMS - STREAM_ITEMS);
        test_streaming(TOTAL_ITEMS);

        start <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d items (%0d tallies, %0d lookups), %0d reads, %0d dropped bytes",
                 items_sent, tallies_sent, lookups_sent, reads_ended, dropped_bytes);
        $display("%0d results checked, %0d mismatches", results_checked, error_count);
        if (error_count == 0)
            $display("per_position_score_histogram_tb: done, clean");
        else
            $display("per_position_score_histogram_tb: done, errors");
        $finish;
    end

endmodule
